// ----- rtl/core/emtt_pkg.sv -----
// Shared types, constants and helpers for the event merge table.
`default_nettype none
package emtt_pkg;

	localparam int CAPACITY  = 64;
	localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int RING_W    = SLOT_W + 1;
	localparam int TIMEOUT_W = 31;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 31'd10000;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// input commands
	localparam logic [1:0] CMD_TOF     = 2'd0;
	localparam logic [1:0] CMD_TRACKER = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;

	// result kinds
	localparam logic KIND_CLOSED  = 1'b0;
	localparam logic KIND_DROPPED = 1'b1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] hit_id;
	} in_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] out_event_id;
		logic [15:0] tof_count;
		logic [15:0] tracker_count;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] created;
		logic [15:0] tof;
		logic [15:0] trk;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HIT_RD,
		ST_HIT_CMP,
		ST_HIT_DROP,
		ST_TICK_RD,
		ST_TICK_CHK,
		ST_TICK_FLUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic idx_inc;
		logic rd_scan;
		logic rd_oldest;
		logic wr_hit;
		logic wr_new;
		logic emit_drop;
		logic evict;
		logic flush;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;
		logic match;
		logic full;
		logic open_zero;
		logic too_old;
		logic pend_v;
		logic out_free;
	} dp_status_t;

	// ring slot at an offset from the oldest entry; sum stays below 2*CAPACITY
	function automatic logic [SLOT_W-1:0] ring_slot(input logic [SLOT_W-1:0] base,
	                                                input logic [RING_W-1:0] off);
		logic [RING_W-1:0] s;
		s = {1'b0, base} + off;
		if (s >= RING_W'(CAPACITY))
			s = s - RING_W'(CAPACITY);
		return s[SLOT_W-1:0];
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/emtt_ctrl.sv -----
// Controller state machine for hit lookup and tick eviction.
`default_nettype none
module emtt_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [1:0]            in_cmd,
	input  wire emtt_pkg::dp_status_t  st,
	output logic                       in_ready,
	output emtt_pkg::ctrl_cmd_t        cmd
);

	emtt_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= emtt_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			emtt_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == emtt_pkg::CMD_TICK)
						state_d = emtt_pkg::ST_TICK_RD;
					else if (in_cmd == emtt_pkg::CMD_TOF || in_cmd == emtt_pkg::CMD_TRACKER)
						state_d = emtt_pkg::ST_HIT_RD;
				end
			end
			emtt_pkg::ST_HIT_RD: begin
				if (!st.scan_end)
					state_d = emtt_pkg::ST_HIT_CMP;
				else if (st.full)
					state_d = emtt_pkg::ST_HIT_DROP;
				else
					state_d = emtt_pkg::ST_IDLE;
			end
			emtt_pkg::ST_HIT_CMP:
				state_d = st.match ? emtt_pkg::ST_IDLE : emtt_pkg::ST_HIT_RD;
			emtt_pkg::ST_HIT_DROP:
				if (st.out_free) state_d = emtt_pkg::ST_IDLE;
			emtt_pkg::ST_TICK_RD:
				state_d = st.open_zero ? emtt_pkg::ST_TICK_FLUSH : emtt_pkg::ST_TICK_CHK;
			emtt_pkg::ST_TICK_CHK: begin
				if (!st.too_old)
					state_d = emtt_pkg::ST_TICK_FLUSH;
				else if (!st.pend_v || st.out_free)
					state_d = emtt_pkg::ST_TICK_RD;
			end
			emtt_pkg::ST_TICK_FLUSH:
				if (!st.pend_v || st.out_free) state_d = emtt_pkg::ST_IDLE;
			default: state_d = emtt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			emtt_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			emtt_pkg::ST_HIT_RD: begin
				cmd.rd_scan = !st.scan_end;
				cmd.wr_new  = st.scan_end && !st.full;
			end
			emtt_pkg::ST_HIT_CMP: begin
				cmd.wr_hit  = st.match;
				cmd.idx_inc = !st.match;
			end
			emtt_pkg::ST_HIT_DROP:
				cmd.emit_drop = st.out_free;
			emtt_pkg::ST_TICK_RD:
				cmd.rd_oldest = !st.open_zero;
			emtt_pkg::ST_TICK_CHK:
				cmd.evict = st.too_old && (!st.pend_v || st.out_free);
			emtt_pkg::ST_TICK_FLUSH:
				cmd.flush = st.pend_v && st.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/emtt_dpath.sv -----
// Datapath: entry memory, ring pointers, tick counter, pending and output registers.
`default_nettype none
module emtt_dpath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire emtt_pkg::in_t                       in_data,
	input  wire logic                                cfg_valid,
	input  wire logic [emtt_pkg::TIMEOUT_W-1:0]      cfg_data,
	input  wire logic                                out_ready,
	input  wire emtt_pkg::ctrl_cmd_t                 cmd,
	output emtt_pkg::dp_status_t                     st,
	output logic                                     out_valid,
	output emtt_pkg::out_t                           out_data
);

	emtt_pkg::entry_t mem [emtt_pkg::CAPACITY];
	emtt_pkg::entry_t rd_q;

	logic [emtt_pkg::SLOT_W-1:0]    oldest_q;
	logic [emtt_pkg::CNT_W-1:0]     open_q;
	logic [emtt_pkg::CNT_W-1:0]     idx_q;
	logic [31:0]                    now_q;
	logic [emtt_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [1:0]                     cmd_q;
	logic [31:0]                    id_q;
	logic                           pend_v_q;
	emtt_pkg::out_t                 pend_q;
	logic                           out_v_q;
	emtt_pkg::out_t                 out_q;

	logic [emtt_pkg::SLOT_W-1:0] scan_slot, tail_slot, rd_addr, wr_addr, oldest_nxt;
	logic                        wr_en;
	emtt_pkg::entry_t            wr_data;
	logic [31:0]                 age;
	logic                        out_free;

	assign scan_slot  = emtt_pkg::ring_slot(oldest_q, emtt_pkg::RING_W'(idx_q));
	assign tail_slot  = emtt_pkg::ring_slot(oldest_q, emtt_pkg::RING_W'(open_q));
	assign oldest_nxt = (oldest_q == emtt_pkg::SLOT_W'(emtt_pkg::CAPACITY - 1)) ?
	                    '0 : oldest_q + 1'b1;
	assign age        = now_q - rd_q.created;
	assign out_free   = !out_v_q || out_ready;

	// status to controller
	always_comb begin
		st.scan_end  = (idx_q == open_q);
		st.match     = (rd_q.id == id_q);
		st.full      = (open_q == emtt_pkg::CNT_W'(emtt_pkg::CAPACITY));
		st.open_zero = (open_q == '0);
		st.too_old   = (age > {1'b0, timeout_q});
		st.pend_v    = pend_v_q;
		st.out_free  = out_free;
	end

	// memory port selection and write data
	always_comb begin
		rd_addr = cmd.rd_oldest ? oldest_q : scan_slot;
		wr_en   = cmd.wr_hit || cmd.wr_new;
		wr_addr = cmd.wr_new ? tail_slot : scan_slot;
		if (cmd.wr_new) begin
			wr_data.id      = id_q;
			wr_data.created = now_q;
			wr_data.tof     = (cmd_q == emtt_pkg::CMD_TOF) ? 16'd1 : 16'd0;
			wr_data.trk     = (cmd_q == emtt_pkg::CMD_TRACKER) ? 16'd1 : 16'd0;
		end else begin
			wr_data     = rd_q;
			if (cmd_q == emtt_pkg::CMD_TOF)
				wr_data.tof = emtt_pkg::sat_inc(rd_q.tof);
			else
				wr_data.trk = emtt_pkg::sat_inc(rd_q.trk);
		end
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd_scan || cmd.rd_oldest)
			rd_q <= mem[rd_addr];
	end

	// item capture and scan index
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= in_data.cmd;
			id_q  <= in_data.hit_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (cmd.latch)
			idx_q <= '0;
		else if (cmd.idx_inc)
			idx_q <= idx_q + 1'b1;
	end

	// ring pointers, tick counter, timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q  <= '0;
			open_q    <= '0;
			now_q     <= '0;
			timeout_q <= emtt_pkg::TIMEOUT_RESET;
		end else begin
			if (cfg_valid)
				timeout_q <= cfg_data;
			if (cmd.latch && in_data.cmd == emtt_pkg::CMD_TICK)
				now_q <= now_q + 32'd1;
			if (cmd.wr_new)
				open_q <= open_q + 1'b1;
			else if (cmd.evict) begin
				open_q   <= open_q - 1'b1;
				oldest_q <= oldest_nxt;
			end
		end
	end

	// pending eviction: held until it is known whether it is the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_v_q <= 1'b0;
		else if (cmd.evict)
			pend_v_q <= 1'b1;
		else if (cmd.flush)
			pend_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.evict) begin
			pend_q.kind          <= emtt_pkg::KIND_CLOSED;
			pend_q.out_event_id  <= rd_q.id;
			pend_q.tof_count     <= rd_q.tof;
			pend_q.tracker_count <= rd_q.trk;
			pend_q.last          <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (cmd.emit_drop || cmd.flush || (cmd.evict && pend_v_q))
			out_v_q <= 1'b1;
		else if (out_ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_drop) begin
			out_q.kind          <= emtt_pkg::KIND_DROPPED;
			out_q.out_event_id  <= id_q;
			out_q.tof_count     <= '0;
			out_q.tracker_count <= '0;
			out_q.last          <= 1'b1;
		end else if (cmd.flush) begin
			out_q      <= pend_q;
			out_q.last <= 1'b1;
		end else if (cmd.evict && pend_v_q) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ----- rtl/core/event_merge_table_with_timeout.sv -----
// Top level of the event merge table with timeout.
//
//  channel | signals                      | payload
//  --------+------------------------------+------------------------------
//  in      | in_valid / in_ready          | in_data   (cmd, hit_id)
//  out     | out_valid / out_ready        | out_data  (kind, id, counts, last)
//  cfg     | cfg_valid / cfg_ready        | cfg_data  (timeout_ticks)
//
// A hit scans the open entries one at a time (read, then compare) through
// the entry memory and ends in one write, or in a drop result when full.
// A tick evicts the oldest entries while too old; out_ready stalls hold it.
// Reset clears pointers, counters and the tick count; the timeout resets to 10000.
// Input is taken only in idle; the output register lets work go on under a stall.
`default_nettype none
module event_merge_table_with_timeout (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire emtt_pkg::in_t                   in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output emtt_pkg::out_t                       out_data,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [emtt_pkg::TIMEOUT_W-1:0]  cfg_data
);

	emtt_pkg::ctrl_cmd_t  cmd;
	emtt_pkg::dp_status_t st;

	assign cfg_ready = 1'b1;

	emtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.cmd),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	emtt_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ----- test/tb_event_merge_table_with_timeout.sv -----
// Self-checking testbench for the event merge table with timeout.
`default_nettype none

// Tracks the open-event table and holds the results the block owes us.
class event_table_sb;
	bit [31:0] ids [64];
	bit [31:0] created [64];
	bit [15:0] tof [64];
	bit [15:0] trk [64];
	int unsigned oldest_slot;
	int unsigned open_count;
	bit [31:0] now_ticks;
	bit [30:0] timeout_ticks;
	emtt_pkg::out_t pending[$];
	int unsigned errors;

	function new();
		oldest_slot = 0;
		open_count = 0;
		now_ticks = 0;
		timeout_ticks = emtt_pkg::TIMEOUT_RESET;
		errors = 0;
	endfunction

	// Advance the table for one accepted input transfer
	function void note_input(emtt_pkg::in_t it);
		emtt_pkg::out_t r;
		int unsigned i, s, n;
		bit [31:0] age;
		n = 0;
		if (it.cmd == emtt_pkg::CMD_TICK) begin
			now_ticks = now_ticks + 1;
			while (open_count > 0) begin
				s = oldest_slot;
				age = now_ticks - created[s];
				if (age <= {1'b0, timeout_ticks})
					break;
				r.kind = emtt_pkg::KIND_CLOSED;
				r.out_event_id = ids[s];
				r.tof_count = tof[s];
				r.tracker_count = trk[s];
				r.last = 1'b0;
				pending = {pending, r};
				n++;
				oldest_slot = (oldest_slot + 1) % 64;
				open_count--;
			end
			if (n > 0)
				pending[$].last = 1'b1;
			return;
		end
		if (it.cmd != emtt_pkg::CMD_TOF && it.cmd != emtt_pkg::CMD_TRACKER)
			return;
		for (i = 0; i < open_count; i++)
			if (ids[(oldest_slot + i) % 64] == it.hit_id)
				break;
		s = (oldest_slot + i) % 64;
		if (i == open_count) begin
			if (open_count >= 64) begin
				r.kind = emtt_pkg::KIND_DROPPED;
				r.out_event_id = it.hit_id;
				r.tof_count = 0;
				r.tracker_count = 0;
				r.last = 1'b1;
				pending = {pending, r};
				return;
			end
			ids[s] = it.hit_id;
			created[s] = now_ticks;
			tof[s] = 0;
			trk[s] = 0;
			open_count++;
		end
		if (it.cmd == emtt_pkg::CMD_TOF) begin
			if (tof[s] != 16'hFFFF)
				tof[s] = tof[s] + 1;
		end else begin
			if (trk[s] != 16'hFFFF)
				trk[s] = trk[s] + 1;
		end
	endfunction

	// Compare one output transfer with the oldest expectation
	function void check_result(emtt_pkg::out_t got);
		emtt_pkg::out_t exp_r;
		if (pending.size() == 0) begin
			$error("unexpected result id %h", got.out_event_id);
			errors++;
			return;
		end
		exp_r = pending[0];
		pending.delete(0);
		if (got.kind != exp_r.kind) begin
			$error("kind: expected %0d actual %0d", exp_r.kind, got.kind);
			errors++;
		end
		if (got.out_event_id != exp_r.out_event_id) begin
			$error("out_event_id: expected %h actual %h", exp_r.out_event_id,
				got.out_event_id);
			errors++;
		end
		if (got.tof_count != exp_r.tof_count) begin
			$error("tof_count: expected %0d actual %0d", exp_r.tof_count, got.tof_count);
			errors++;
		end
		if (got.tracker_count != exp_r.tracker_count) begin
			$error("tracker_count: expected %0d actual %0d", exp_r.tracker_count,
				got.tracker_count);
			errors++;
		end
		if (got.last != exp_r.last) begin
			$error("last: expected %0d actual %0d", exp_r.last, got.last);
			errors++;
		end
	endfunction
endclass

module tb_event_merge_table_with_timeout;
	import emtt_pkg::*;

	localparam int SETTLE_CYCLES = 300;
	localparam int STALL_LIMIT = 20000;
	// command code with no function in the block
	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [TIMEOUT_W-1:0] cfg_data;

	event_table_sb sb;
	bit hold_req;
	bit no_gaps;
	int burst_left;
	int idle_cycles;
	bit [31:0] id_pool [6];

	event_merge_table_with_timeout i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver stall pattern, with a long hold-off on request
	always @(negedge clk) begin
		int i;
		if (hold_req) begin
			out_ready = 1'b0;
			for (i = 0; i < 400; i++)
				@(negedge clk);
			hold_req = 1'b0;
		end else if ($urandom_range(0, 15) == 0) begin
			out_ready = 1'b1;
			for (i = $urandom_range(5, 40); i > 0; i--)
				@(negedge clk);
		end else begin
			out_ready = ($urandom_range(0, 2) != 0);
		end
	end

	// Result checking
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// One input transfer, then a random gap at the end of a burst
	task automatic send_item(input logic [1:0] cmd, input logic [31:0] id);
		in_t it;
		it.cmd = cmd;
		it.hit_id = id;
		@(negedge clk);
		in_valid = 1'b1;
		in_data = it;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(it);
		if (!no_gaps) begin
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 10);
				@(negedge clk);
				in_valid = 1'b0;
				repeat ($urandom_range(0, 6))
					@(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Wait until every expected result has arrived and the block is quiet
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.timeout_ticks = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		int i, p;
		int unsigned r;
		logic [31:0] id;
		logic [TIMEOUT_W-1:0] tmo;
		sb = new();
		hold_req = 1'b0;
		no_gaps = 1'b0;
		burst_left = 0;
		idle_cycles = 0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Id extremes, unused command, tick under default timeout, then under zero timeout
		send_item(CMD_SPARE, 32'h0);
		send_item(CMD_TOF, 32'h0);
		send_item(CMD_TRACKER, 32'hFFFF_FFFF);
		send_item(CMD_TOF, 32'hFFFF_FFFF);
		send_item(CMD_TICK, $urandom());
		settle();
		write_timeout('0);
		send_item(CMD_TICK, 32'h0);
		settle();

		// Fill the table, then drop new ids
		write_timeout({TIMEOUT_W{1'b1}});
		for (i = 0; i < 64; i++)
			send_item(CMD_TRACKER, {i[7:0], 24'($urandom_range(0, 24'hFFFFFF))});
		send_item(CMD_TOF, 32'hDEAD_0001);
		send_item(CMD_TRACKER, 32'hDEAD_0002);
		send_item(CMD_TICK, 32'h0);
		settle();

		// Mass eviction under a long receiver hold-off; input backs up
		write_timeout('0);
		hold_req = 1'b1;
		send_item(CMD_TICK, 32'h0);
		for (i = 0; i < 10; i++)
			send_item(i[0] ? CMD_TOF : CMD_TRACKER, $urandom());
		send_item(CMD_TICK, 32'h0);
		settle();

		// Random phases with short timeouts
		for (p = 0; p < 2; p++) begin
			tmo = (p == 1) ? TIMEOUT_W'($urandom_range(0, 8)) : TIMEOUT_W'(p + 1);
			write_timeout(tmo);
			for (i = 0; i < 6; i++)
				id_pool[i] = $urandom();
			for (i = 0; i < 16; i++) begin
				r = $urandom_range(0, 99);
				id = (r % 4 == 0) ? $urandom() : id_pool[$urandom_range(0, 5)];
				if (r < 28)
					send_item(CMD_TICK, $urandom());
				else if (r < 32)
					send_item(CMD_SPARE, $urandom());
				else
					send_item(r[0] ? CMD_TOF : CMD_TRACKER, id);
			end
			send_item(CMD_TICK, 32'h0);
			settle();
		end

		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

`default_nettype wire
